>>> rtl/core/hsvcc_pkg.sv
package hsvcc_pkg;

    localparam int NUM_WIN = 5;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_BLUE   = 3'd1,
        CLS_ORANGE = 3'd2,
        CLS_PINK   = 3'd3,
        CLS_GREEN  = 3'd4,
        CLS_YELLOW = 3'd5
    } t_class;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLASS,
        ST_PIXEL,
        ST_SUMMARY
    } t_state;

    localparam logic [1:0] ADDR_FRAME_WIDTH = 2'd0;

    typedef struct packed {
        logic load;
        logic div_step;
        logic classify;
        logic emit_pixel;
        logic emit_summary;
        logic clear_frame;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic eof;
        logic sum_last;
    } t_status;

    typedef struct packed {
        logic [8:0]  centre;
        logic [6:0]  v_lo;
        logic [6:0]  v_hi;
        logic [6:0]  s_lo;
        logic [6:0]  s_hi;
        logic [23:0] rgb;
    } t_window;

    function automatic t_window window_of(input logic [2:0] k);
        t_window w;
        case (k)
            3'd0:    w = '{9'd199, 7'd23, 7'd100, 7'd40, 7'd60, 24'hFF0000};
            3'd1:    w = '{9'd9, 7'd40, 7'd100, 7'd80, 7'd100, 24'h00FF00};
            3'd2:    w = '{9'd339, 7'd40, 7'd100, 7'd75, 7'd100, 24'h0000FF};
            3'd3:    w = '{9'd116, 7'd36, 7'd70, 7'd40, 7'd60, 24'h00FFFF};
            default: w = '{9'd72, 7'd75, 7'd100, 7'd30, 7'd80, 24'hFFFFFF};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/hsv_color_classifier_centroid.sv
// HSV colour classifier: one RGB word in, one pixel word out (recoloured on a
// match in priority blue, orange, pink, green, yellow), and five summary words
// with per-class x/y sums and counts after a word marked end_of_frame. Each
// word runs through the 21-step bit-serial hue divider; no new word is taken
// until its output words are sent. frame_width lies at address 0.
module hsv_color_classifier_centroid
    import hsvcc_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_PIXELS = 2097152,
    parameter int NUM_COLORS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_end_of_frame,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [2:0]  o_color_class,
    output logic        o_is_summary,
    output logic [31:0] o_sum_x,
    output logic [31:0] o_sum_y,
    output logic [21:0] o_pixel_count,
    output logic        o_last
);

    logic [11:0] r_frame_width;
    t_cmd        cmd;
    t_status     status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FRAME_WIDTH) ? {20'd0, r_frame_width} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= 12'd1080;
        end else if (psel && penable && pwrite && paddr == ADDR_FRAME_WIDTH) begin
            r_frame_width <= pwdata[11:0];
        end
    end

    hsvcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    hsvcc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_PIXELS (MAX_PIXELS),
        .NUM_COLORS (NUM_COLORS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_frame_width  (r_frame_width),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_end_of_frame (i_end_of_frame),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_color_class  (o_color_class),
        .o_is_summary   (o_is_summary),
        .o_sum_x        (o_sum_x),
        .o_sum_y        (o_sum_y),
        .o_pixel_count  (o_pixel_count),
        .o_last         (o_last)
    );

endmodule

>>> rtl/core/hsvcc_ctrl.sv
module hsvcc_ctrl
    import hsvcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_stall,
    output logic    o_valid,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state        = ST_PIXEL;
            end
            ST_PIXEL: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.emit_pixel = 1'b1;
                    n_state = i_status.eof ? ST_SUMMARY : ST_IDLE;
                end
            end
            ST_SUMMARY: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.emit_summary = 1'b1;
                    if (i_status.sum_last) begin
                        o_cmd.clear_frame = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/hsvcc_dp.sv
module hsvcc_dp
    import hsvcc_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_PIXELS = 2097152,
    parameter int NUM_COLORS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [11:0] i_frame_width,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_end_of_frame,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [2:0]  o_color_class,
    output logic        o_is_summary,
    output logic [31:0] o_sum_x,
    output logic [31:0] o_sum_y,
    output logic [21:0] o_pixel_count,
    output logic        o_last
);

    localparam int NC  = (NUM_COLORS < NUM_WIN) ? NUM_COLORS : NUM_WIN;
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int CNW = $clog2(MAX_PIXELS + 1);

    logic [7:0]  r_r, r_g, r_b;
    logic        r_eof;
    logic [7:0]  r_mx, r_d;
    logic        r_neg;
    logic [1:0]  r_sel;
    logic [CW-1:0] r_col;
    logic [10:0] r_row;
    logic [2:0]  r_cls;
    logic [2:0]  r_sidx;
    logic [31:0] r_xs [NC];
    logic [31:0] r_ys [NC];
    logic [CNW-1:0] r_cn [NC];

    logic [7:0]  mx, mn;
    logic [1:0]  sel;
    logic signed [8:0] nd;
    logic [8:0]  nabs;
    logic signed [15:0] hue_s;
    logic [14:0] hue;
    logic [2:0]  cls;
    logic [12:0] eff;
    logic [CW:0] col_inc;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (i_blue > mx) ? i_blue : mx;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (i_blue < mn) ? i_blue : mn;
        if (mx == i_red) begin
            sel = 2'd0;
            nd  = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (mx == i_green) begin
            sel = 2'd1;
            nd  = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            sel = 2'd2;
            nd  = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        nabs = nd[8] ? 9'(-nd) : 9'(nd);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r   <= i_red;
            r_g   <= i_green;
            r_b   <= i_blue;
            r_eof <= i_end_of_frame;
            r_mx  <= mx;
            r_d   <= mx - mn;
            r_sel <= sel;
            r_neg <= nd[8];
        end
    end

    // restoring division of 3840*|n| by d, 21 quotient bits
    logic [20:0] r_prod;
    logic [20:0] r_q2;
    logic [8:0]  r_rm2;
    logic [9:0]  trial2;
    assign trial2 = {r_rm2, r_prod[20]} - {2'd0, r_d};

    logic [4:0] r_step;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= 21'(nabs) * 21'd3840;
            r_q2   <= '0;
            r_rm2  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rm2  <= trial2[9] ? 9'({r_rm2, r_prod[20]}) : trial2[8:0];
            r_q2   <= {r_q2[19:0], ~trial2[9]};
            r_prod <= {r_prod[19:0], 1'b0};
            r_step <= r_step + 5'd1;
        end
    end

    assign o_status = '{div_done: (r_step == 5'd20) && i_cmd.div_step,
                        eof:      r_eof,
                        sum_last: (r_sidx == 3'(NC - 1))};

    always_comb begin
        logic signed [15:0] q;
        q = (r_d == 8'd0) ? 16'sd0 : (r_neg ? -$signed({1'b0, r_q2[14:0]})
                                              : $signed({1'b0, r_q2[14:0]}));
        if (r_d == 8'd0) begin
            hue_s = 16'sd0;
        end else begin
            hue_s = q + $signed({8'd0, r_sel, 6'd0}) * 16'sd120;
        end
        if (hue_s < 0) begin
            hue_s = hue_s + 16'sd23040;
        end
        hue = 15'(hue_s);
    end

    always_comb begin
        t_window w;
        logic hok, vok, sok;
        cls = CLS_NONE;
        for (int k = NC - 1; k >= 0; k--) begin
            w = window_of(3'(k));
            if (k == 1) begin
                hok = (hue > 15'd192) && (hue < 15'd960);
            end else begin
                hok = (25'(hue) * 25'd1000 < 25'(w.centre) * 25'd68800) &&
                      (25'(hue) * 25'd1000 > 25'(w.centre) * 25'd59200);
            end
            vok = (15'(r_mx) * 15'd100 > 15'(w.v_lo) * 15'd255) &&
                  (15'(r_mx) * 15'd100 < 15'(w.v_hi) * 15'd255);
            sok = (15'(r_d) * 15'd100 > 15'(w.s_lo) * 15'(r_mx)) &&
                  (15'(r_d) * 15'd100 < 15'(w.s_hi) * 15'(r_mx));
            if (hok && vok && sok) begin
                cls = 3'(k + 1);
            end
        end
    end

    assign eff     = (i_frame_width == 12'd0 || 13'(i_frame_width) > 13'(MAX_WIDTH))
                     ? 13'(MAX_WIDTH) : 13'(i_frame_width);
    assign col_inc = (CW + 1)'(r_col) + (CW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_sidx <= '0;
            for (int k = 0; k < NC; k++) begin
                r_xs[k] <= '0;
                r_ys[k] <= '0;
                r_cn[k] <= '0;
            end
        end else begin
            if (i_cmd.classify) begin
                r_cls <= cls;
                if (cls != CLS_NONE && r_cn[cls - 3'd1] < CNW'(MAX_PIXELS)) begin
                    r_xs[cls - 3'd1] <= r_xs[cls - 3'd1] + 32'(r_col);
                    r_ys[cls - 3'd1] <= r_ys[cls - 3'd1] + 32'(r_row);
                    r_cn[cls - 3'd1] <= r_cn[cls - 3'd1] + CNW'(1);
                end
            end
            if (i_cmd.emit_pixel) begin
                if (32'(col_inc) >= 32'(eff)) begin
                    r_col <= '0;
                    r_row <= r_row + 11'd1;
                end else begin
                    r_col <= CW'(col_inc);
                end
                r_sidx <= '0;
            end
            if (i_cmd.emit_summary) begin
                r_sidx <= r_sidx + 3'd1;
            end
            if (i_cmd.clear_frame) begin
                r_col <= '0;
                r_row <= '0;
                for (int k = 0; k < NC; k++) begin
                    r_xs[k] <= '0;
                    r_ys[k] <= '0;
                    r_cn[k] <= '0;
                end
            end
        end
    end

    always_comb begin
        t_window w;
        w = window_of(r_cls - 3'd1);
        if (i_cmd.emit_summary || (o_is_summary)) begin
            o_out_red     = '0;
            o_out_green   = '0;
            o_out_blue    = '0;
            o_color_class = r_sidx + 3'd1;
            o_sum_x       = r_xs[r_sidx];
            o_sum_y       = r_ys[r_sidx];
            o_pixel_count = 22'(r_cn[r_sidx]);
            o_last        = (r_sidx == 3'(NC - 1));
        end else begin
            o_out_red     = (r_cls == CLS_NONE) ? r_r : w.rgb[23:16];
            o_out_green   = (r_cls == CLS_NONE) ? r_g : w.rgb[15:8];
            o_out_blue    = (r_cls == CLS_NONE) ? r_b : w.rgb[7:0];
            o_color_class = r_cls;
            o_sum_x       = '0;
            o_sum_y       = '0;
            o_pixel_count = '0;
            o_last        = !r_eof;
        end
    end

    logic r_in_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sum <= 1'b0;
        end else if (i_cmd.emit_pixel) begin
            r_in_sum <= r_eof;
        end else if (i_cmd.clear_frame) begin
            r_in_sum <= 1'b0;
        end
    end
    assign o_is_summary = r_in_sum;

endmodule

>>> rtl/core/hsvcc_checker.sv
module hsvcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_is_summary,
    input logic [2:0] o_color_class,
    input logic [7:0] o_out_red
);

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while word pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("output word dropped");

    a_summary_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary |-> o_out_red == 8'd0) else $error("summary not black");

    a_summary_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary |-> o_color_class != 3'd0) else $error("summary class");

endmodule

bind hsv_color_classifier_centroid hsvcc_checker u_hsvcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_is_summary  (o_is_summary),
    .o_color_class (o_color_class),
    .o_out_red     (o_out_red)
);

>>> test/hsv_color_classifier_centroid_chk.sv
module hsv_color_classifier_centroid_chk
    import hsvcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_end_of_frame,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_out_red,
    input  logic [7:0]  o_out_green,
    input  logic [7:0]  o_out_blue,
    input  logic [2:0]  o_color_class,
    input  logic        o_is_summary,
    input  logic [31:0] o_sum_x,
    input  logic [31:0] o_sum_y,
    input  logic [21:0] o_pixel_count,
    input  logic        o_last,
    output int          o_fails,
    output int          o_pending
);

    localparam int WIDTH_CAP = 2048;
    localparam int PIXEL_CAP = 2097152;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        t_class      cls;
        logic        summ;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [21:0] cnt;
        logic        last;
    } t_word;

    localparam int         CENTRE [5] = '{199, 9, 339, 116, 72};
    localparam int         V_LO   [5] = '{23, 40, 40, 36, 75};
    localparam int         V_HI   [5] = '{100, 100, 100, 70, 100};
    localparam int         S_LO   [5] = '{40, 80, 75, 40, 30};
    localparam int         S_HI   [5] = '{60, 100, 100, 60, 80};
    localparam logic [23:0] PAINT [5] = '{24'hFF0000, 24'h00FF00, 24'h0000FF,
                                          24'h00FFFF, 24'hFFFFFF};

    t_word       expected_words[$];
    logic [11:0] width_reg;
    int          col;
    int          row;
    logic [31:0] x_acc [5];
    logic [31:0] y_acc [5];
    int          n_acc [5];

    assign o_pending = expected_words.size();

    function automatic bit in_window(int k, int hue, int mx, int d);
        bit hue_ok;
        if (k == 1)
            hue_ok = hue > 192 && hue < 960;
        else
            hue_ok = 1000 * hue < 64 * CENTRE[k] * 1075 &&
                     1000 * hue > 64 * CENTRE[k] * 925;
        return hue_ok && 100 * mx > V_LO[k] * 255 && 100 * mx < V_HI[k] * 255 &&
               100 * d > S_LO[k] * mx && 100 * d < S_HI[k] * mx;
    endfunction

    task automatic classify_pixel(input int r, input int g, input int b, input bit eof);
        int    mx, mn, d, hue, base, n, eff;
        int    hit;
        t_word w;
        mx = r > g ? r : g;
        mx = b > mx ? b : mx;
        mn = r < g ? r : g;
        mn = b < mn ? b : mn;
        d = mx - mn;
        hue = 0;
        if (d != 0) begin
            if (mx == r) begin
                base = 0;
                n = g - b;
            end else if (mx == g) begin
                base = 120;
                n = b - r;
            end else begin
                base = 240;
                n = r - g;
            end
            hue = (3840 * n) / d + base * 64;
            if (hue < 0)
                hue += 23040;
        end
        hit = -1;
        for (int k = 0; k < 5; k++) begin
            if (hit < 0 && in_window(k, hue, mx, d))
                hit = k;
        end
        w = '{r[7:0], g[7:0], b[7:0], CLS_NONE, 1'b0, 32'd0, 32'd0, 22'd0, !eof};
        if (hit >= 0) begin
            {w.red, w.green, w.blue} = PAINT[hit];
            w.cls = t_class'(hit + 1);
            if (n_acc[hit] < PIXEL_CAP) begin
                x_acc[hit] += col;
                y_acc[hit] += row;
                n_acc[hit]++;
            end
        end
        expected_words.push_back(w);
        eff = (width_reg == 0 || width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        col++;
        if (col >= eff) begin
            col = 0;
            row = (row + 1) & 11'h7FF;
        end
        if (eof) begin
            for (int k = 0; k < 5; k++) begin
                w = '{8'd0, 8'd0, 8'd0, t_class'(k + 1), 1'b1, x_acc[k], y_acc[k],
                      n_acc[k][21:0], k == 4};
                expected_words.push_back(w);
                x_acc[k] = 0;
                y_acc[k] = 0;
                n_acc[k] = 0;
            end
            col = 0;
            row = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_word e;
        if (!i_rst_n) begin
            width_reg = 12'd1080;
            col = 0;
            row = 0;
            for (int k = 0; k < 5; k++) begin
                x_acc[k] = 0;
                y_acc[k] = 0;
                n_acc[k] = 0;
            end
            expected_words.delete();
            o_fails <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_FRAME_WIDTH)
                width_reg = pwdata[11:0];
            if (i_valid && !o_stall)
                classify_pixel(i_red, i_green, i_blue, i_end_of_frame);
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word class %0d", $time, o_color_class);
                    o_fails <= o_fails + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (o_out_red !== e.red || o_out_green !== e.green ||
                        o_out_blue !== e.blue || o_color_class !== e.cls ||
                        o_is_summary !== e.summ || o_sum_x !== e.sx ||
                        o_sum_y !== e.sy || o_pixel_count !== e.cnt ||
                        o_last !== e.last) begin
                        $display("%0t: exp %h %h %h c%0d s%0d %0d %0d %0d l%0d", $time,
                                 e.red, e.green, e.blue, e.cls, e.summ, e.sx, e.sy,
                                 e.cnt, e.last);
                        $display("%0t: got %h %h %h c%0d s%0d %0d %0d %0d l%0d", $time,
                                 o_out_red, o_out_green, o_out_blue, o_color_class,
                                 o_is_summary, o_sum_x, o_sum_y, o_pixel_count, o_last);
                        o_fails <= o_fails + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/hsv_color_classifier_centroid_tb.sv
module hsv_color_classifier_centroid_tb
    import hsvcc_pkg::*;
;

    localparam int IDLE_LIMIT = 8000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        i_end_of_frame = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [2:0]  o_color_class;
    logic        o_is_summary;
    logic [31:0] o_sum_x;
    logic [31:0] o_sum_y;
    logic [21:0] o_pixel_count;
    logic        o_last;
    int          fails;
    int          pending;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    hsv_color_classifier_centroid u_top (.*);

    hsv_color_classifier_centroid_chk u_chk (
        .*,
        .o_fails   (fails),
        .o_pending (pending)
    );

    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 6) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(8, 40);
        end else if ($urandom_range(0, 99) < 25) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
            stall_left <= $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("hsv_color_classifier_centroid: mismatch");
            $finish;
        end
    end

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_FRAME_WIDTH;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(input int r, input int g, input int b, input bit eof);
        int gap, pick;
        pick = $urandom_range(0, 99);
        gap = quiet ? 0 : pick < 50 ? 0 : pick < 90 ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 30);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= 8'(r);
        i_green <= 8'(g);
        i_blue <= 8'(b);
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (o_stall);
    endtask

    // rough hsv to rgb, hue in degrees
    task automatic send_hsv(input int h, input int mx, input int d, input bit eof);
        int mn, f;
        mn = mx - d;
        f = (h % 60) * d / 60;
        case (h / 60)
            0: send(mx, mn + f, mn, eof);
            1: send(mx - f, mx, mn, eof);
            2: send(mn, mx, mn + f, eof);
            3: send(mn, mx - f, mx, eof);
            4: send(mn + f, mn, mx, eof);
            default: send(mx, mn, mx - f, eof);
        endcase
    endtask

    task automatic send_random(input bit eof);
        int centres [5] = '{199, 9, 339, 116, 72};
        int mx;
        if ($urandom_range(0, 99) < 60) begin
            mx = $urandom_range(40, 255);
            send_hsv((centres[$urandom_range(0, 4)] + 360 + $urandom_range(0, 24) - 12)
                     % 360, mx, mx * $urandom_range(20, 100) / 100, eof);
        end else begin
            send($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 eof);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ties, one pixel per class, reset width
        send(0, 0, 0, 0);
        send(255, 255, 255, 0);
        send(255, 255, 0, 0);
        send(0, 255, 255, 0);
        send(255, 0, 255, 0);
        send(255, 0, 0, 0);
        send(0, 255, 0, 0);
        send(0, 0, 255, 0);
        send(77, 172, 255, 0);
        send(255, 40, 0, 0);
        send(255, 0, 60, 0);
        send(61, 140, 56, 0);
        send(230, 240, 80, 0);
        send(170, 85, 170, 0);
        send(0, 0, 0, 1);
        drain();

        // one column per line
        write_width(1);
        quiet = 1'b1;
        repeat (8) send_hsv(199, 200, 100, 0);
        send(255, 40, 0, 1);
        quiet = 1'b0;
        drain();

        write_width(2048);
        repeat (8) send_random(0);
        send_random(1);
        drain();
        write_width(0);
        repeat (6) send_random(0);
        drain();
        // width change mid-frame
        write_width(3);
        repeat (6) send_random(0);
        send_random(1);
        drain();
        write_width(4095);
        repeat (4) send_random(0);
        send_random(1);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_width(phase == 3 ? 2048 : $urandom_range(2, 24));
            quiet = phase == 2;
            for (int i = 0; i < 16; i++)
                send_random($urandom_range(0, 99) < 10);
            send_random(1);
            quiet = 1'b0;
            drain();
        end

        drain();
        if (fails == 0)
            $display("hsv_color_classifier_centroid: match");
        else
            $display("hsv_color_classifier_centroid: mismatch");
        $finish;
    end

endmodule

>>> hsv_color_classifier_centroid.f
rtl/core/hsvcc_pkg.sv
rtl/core/hsvcc_ctrl.sv
rtl/core/hsvcc_dp.sv
rtl/core/hsv_color_classifier_centroid.sv
rtl/core/hsvcc_checker.sv
test/hsv_color_classifier_centroid_chk.sv
test/hsv_color_classifier_centroid_tb.sv
